### rtl/ctsa_pkg.sv
// ----------------------------------------------------------------------------
// ctsa_pkg
// Shared types and constants for the clock tick speed adapter.
// ----------------------------------------------------------------------------
package ctsa_pkg;

	localparam logic [7:0] ANCHOR_NONE = 8'd255;

	localparam logic [1:0] MODE_HALF   = 2'd0;
	localparam logic [1:0] MODE_NORMAL = 2'd1;
	localparam logic [1:0] MODE_DOUBLE = 2'd2;

	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [63:0] now_us;
		logic [31:0] tick_stamp;
		logic [1:0]  tick_source;
		logic        tick_resync;
		logic        tick_downbeat;
		logic [7:0]  tick_anchor;
	} item_t;

	typedef struct packed {
		logic [1:0]  source;
		logic [31:0] stamp;
		logic        resync;
		logic        downbeat;
		logic [7:0]  anchor;
		logic        inserted;
	} result_t;

endpackage

### rtl/ctsa_core.sv
// ----------------------------------------------------------------------------
// ctsa_core
// Mode register, tick tracking state and the per-beat result logic.
// ----------------------------------------------------------------------------
module ctsa_core
	import ctsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       step,
	input  item_t      item,
	output logic       res_vld,
	output result_t    res
);

	logic [1:0]  speed_mode_q;
	logic        tick_parity_q;
	logic [31:0] last_stamp_q;
	logic [31:0] last_interval_q;
	logic [63:0] insert_time_q;
	logic        insert_armed_q;
	logic [1:0]  held_source_q;

	logic        tick_parity_d;
	logic [31:0] last_stamp_d;
	logic [31:0] last_interval_d;
	logic [63:0] insert_time_d;
	logic        insert_armed_d;
	logic [1:0]  held_source_d;

	logic [31:0] iv_meas;
	logic [64:0] ins_sum;
	logic        fire;

	assign iv_meas = (last_stamp_q != 32'd0) ? (item.tick_stamp - last_stamp_q)
		: last_interval_q;
	assign ins_sum = {1'b0, item.now_us} + {34'd0, iv_meas[31:1]};
	assign fire    = (speed_mode_q == MODE_DOUBLE) && insert_armed_q
		&& (item.now_us >= insert_time_q);

	always_comb begin
		tick_parity_d   = tick_parity_q;
		last_stamp_d    = last_stamp_q;
		last_interval_d = last_interval_q;
		insert_time_d   = insert_time_q;
		insert_armed_d  = insert_armed_q;
		held_source_d   = held_source_q;
		res_vld         = 1'b0;
		res.source      = item.tick_source;
		res.stamp       = item.tick_stamp;
		res.resync      = 1'b0;
		res.downbeat    = item.tick_downbeat;
		res.anchor      = item.tick_anchor;
		res.inserted    = 1'b0;
		if (item.action == ACT_UPDATE) begin
			res.source   = held_source_q;
			res.stamp    = item.now_us[31:0];
			res.downbeat = 1'b0;
			res.anchor   = ANCHOR_NONE;
			res.inserted = 1'b1;
			if (fire) begin
				res_vld        = 1'b1;
				insert_armed_d = 1'b0;
			end
		end else begin
			held_source_d = item.tick_source;
			if (item.tick_resync) begin
				tick_parity_d   = 1'b0;
				last_stamp_d    = 32'd0;
				last_interval_d = 32'd0;
				insert_armed_d  = 1'b0;
				res.resync      = 1'b1;
				res_vld         = 1'b1;
			end else begin
				case (speed_mode_q)
					MODE_HALF: begin
						tick_parity_d   = ~tick_parity_q;
						last_stamp_d    = item.tick_stamp;
						last_interval_d = iv_meas;
						res_vld         = tick_parity_q;
					end
					MODE_NORMAL: begin
						last_stamp_d    = item.tick_stamp;
						last_interval_d = iv_meas;
						res_vld         = 1'b1;
					end
					MODE_DOUBLE: begin
						last_stamp_d    = item.tick_stamp;
						last_interval_d = iv_meas;
						res_vld         = 1'b1;
						if (iv_meas == 32'd0) begin
							insert_armed_d = 1'b0;
						end else begin
							insert_armed_d = 1'b1;
							insert_time_d  = ins_sum[64] ? {64{1'b1}} : ins_sum[63:0];
						end
					end
					default: begin
						res_vld = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_mode_q    <= MODE_NORMAL;
			tick_parity_q   <= 1'b0;
			last_stamp_q    <= 32'd0;
			last_interval_q <= 32'd0;
			insert_time_q   <= 64'd0;
			insert_armed_q  <= 1'b0;
			held_source_q   <= 2'd0;
		end else begin
			if (cfg_wr_en) begin
				speed_mode_q <= cfg_wr_data;
			end
			if (step) begin
				tick_parity_q   <= tick_parity_d;
				last_stamp_q    <= last_stamp_d;
				last_interval_q <= last_interval_d;
				insert_time_q   <= insert_time_d;
				insert_armed_q  <= insert_armed_d;
				held_source_q   <= held_source_d;
			end
		end
	end

	// a fired insert is one-shot
	a_fire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.action == ACT_UPDATE && res_vld |=> !insert_armed_q)
		else $error("insert still armed after firing");

	// resync clears the interval tracking
	a_resync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.action == ACT_TICK && item.tick_resync
		|=> last_stamp_q == 32'd0 && last_interval_q == 32'd0 && !tick_parity_q)
		else $error("resync did not clear state");

	// half mode passes a tick only on the even count
	a_half_parity: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.action == ACT_TICK && !item.tick_resync
		&& speed_mode_q == MODE_HALF |=> tick_parity_q == $past(res_vld) ^ 1'b1)
		else $error("half mode parity mismatch");

	// an insert is armed only in double mode
	a_arm_double: assert property (@(posedge clk) disable iff (!arst_n)
		step && !insert_armed_q && insert_armed_d |-> speed_mode_q == MODE_DOUBLE)
		else $error("insert armed outside double mode");

endmodule

### rtl/ctsa_out_reg.sv
// ----------------------------------------------------------------------------
// ctsa_out_reg
// Result register on the output channel.
// ----------------------------------------------------------------------------
module ctsa_out_reg
	import ctsa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load_vld,
	input  result_t load_res,
	input  logic    out_stall,
	output logic    out_free,
	output logic    out_vld,
	output result_t out_res
);

	logic    vld_q;
	result_t res_q;

	assign out_free = !vld_q || !out_stall;
	assign out_vld  = vld_q;
	assign out_res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= load_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load_vld) begin
			res_q <= load_res;
		end
	end

endmodule

### rtl/clock_tick_speed_adapter_top.sv
// ----------------------------------------------------------------------------
// clock_tick_speed_adapter_top
// Clock tick speed adapter: half, normal or double rate tick forwarding.
// An input beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_stall is low; the state update
// is a single pass, the 64-bit insert-time add and compare setting the path.
// Reset: async arst_n clears valid bits and core state; speed_mode -> normal.
// ----------------------------------------------------------------------------
module clock_tick_speed_adapter_top
	import ctsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [63:0] now_us,
	input  logic [31:0] tick_stamp,
	input  logic [1:0]  tick_source,
	input  logic        tick_resync,
	input  logic        tick_downbeat,
	input  logic [7:0]  tick_anchor,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_source,
	output logic [31:0] out_stamp,
	output logic        out_resync,
	output logic        out_downbeat,
	output logic [7:0]  out_anchor,
	output logic        out_inserted
);

	logic    vld_s1;
	item_t   item_s1;
	logic    out_free;
	logic    step;
	logic    res_vld;
	result_t res;
	result_t out_res;

	assign in_stall = vld_s1 && !out_free;
	assign step     = vld_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action        <= action;
			item_s1.now_us        <= now_us;
			item_s1.tick_stamp    <= tick_stamp;
			item_s1.tick_source   <= tick_source;
			item_s1.tick_resync   <= tick_resync;
			item_s1.tick_downbeat <= tick_downbeat;
			item_s1.tick_anchor   <= tick_anchor;
		end
	end

	ctsa_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.item        (item_s1),
		.res_vld     (res_vld),
		.res         (res)
	);

	ctsa_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_vld  (step && res_vld),
		.load_res  (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_vld   (out_valid),
		.out_res   (out_res)
	);

	assign out_source   = out_res.source;
	assign out_stamp    = out_res.stamp;
	assign out_resync   = out_res.resync;
	assign out_downbeat = out_res.downbeat;
	assign out_anchor   = out_res.anchor;
	assign out_inserted = out_res.inserted;

endmodule
